// ----- src/scancode_to_ascii_fifo_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scancode FIFO
// Clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_ASSERT_SVH

// same-cycle implication
`define SC2A_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SC2A_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sc2a_pkg.sv -----
// ----------------------------------------------------------------------------
// sc2a_pkg
// Word types and operation codes of the scancode FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package sc2a_pkg;

	localparam int FILL_W = 11;

	localparam logic [1:0] OP_SCAN  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] scancode;
	} req_word_t;

	typedef struct packed {
		logic              char_valid;
		logic [7:0]        char_out;
		logic              dropped;
		logic [FILL_W-1:0] fill_level;
	} rsp_word_t;

endpackage

`default_nettype wire

// ----- src/sc2a_if.sv -----
// ----------------------------------------------------------------------------
// sc2a_req_if / sc2a_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc2a_req_if;
	import sc2a_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sc2a_rsp_if;
	import sc2a_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/sc2a_xlate.sv -----
// ----------------------------------------------------------------------------
// sc2a_xlate
// Set-1 make code to ASCII; unknown codes map to '?'.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_xlate (
	input  wire logic [6:0] scancode,
	output logic      [7:0] ascii
);
	logic [6:0] code;

	assign code = scancode;

	always_comb begin
		unique case (code)
			7'h02: ascii = "1";
			7'h03: ascii = "2";
			7'h04: ascii = "3";
			7'h05: ascii = "4";
			7'h06: ascii = "5";
			7'h07: ascii = "6";
			7'h08: ascii = "7";
			7'h09: ascii = "8";
			7'h0a: ascii = "9";
			7'h0b: ascii = "0";
			7'h10: ascii = "q";
			7'h11: ascii = "w";
			7'h12: ascii = "e";
			7'h13: ascii = "r";
			7'h14: ascii = "t";
			7'h15: ascii = "y";
			7'h16: ascii = "u";
			7'h17: ascii = "i";
			7'h18: ascii = "o";
			7'h19: ascii = "p";
			7'h1e: ascii = "a";
			7'h1f: ascii = "s";
			7'h20: ascii = "d";
			7'h21: ascii = "f";
			7'h22: ascii = "g";
			7'h23: ascii = "h";
			7'h24: ascii = "j";
			7'h25: ascii = "k";
			7'h26: ascii = "l";
			7'h2c: ascii = "z";
			7'h2d: ascii = "x";
			7'h2e: ascii = "c";
			7'h2f: ascii = "v";
			7'h30: ascii = "b";
			7'h31: ascii = "n";
			7'h32: ascii = "m";
			7'h39: ascii = " ";
			7'h1c: ascii = 8'h0a;
			default: ascii = "?";
		endcase
	end

endmodule

`default_nettype wire

// ----- src/sc2a_char_ram.sv -----
// ----------------------------------------------------------------------------
// sc2a_char_ram
// Character store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_char_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- src/scancode_to_ascii_fifo.sv -----
// A response word is registered and valid in the cycle after its request is accepted.
// Throughput: one request word per cycle while responses are taken; the
// response register frees when taken; the store needs one read per pop.
// Reset clears pointers, count and response valid at once; the character
// store is not cleared, since only written entries are ever popped.
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// Translates key presses to ASCII and queues them in a ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scancode_to_ascii_fifo_assert.svh"

module scancode_to_ascii_fifo #(
	parameter int FIFO_DEPTH = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	sc2a_req_if.sink   req,
	sc2a_rsp_if.source rsp
);
	import sc2a_pkg::*;

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);

	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          out_vld_q;
	logic          accept, is_press, push, pop, full, clear;
	logic [7:0]    ascii, rd_data;
	logic          char_valid_s1, dropped_s1;
	logic [FILL_W-1:0] fill_s1;

	assign accept   = req.valid && req.ready;
	assign req.ready = !out_vld_q || rsp.ready;
	assign full     = (cnt_q == FULL);
	assign is_press = (req.data.op == OP_SCAN) && !req.data.scancode[7];
	assign push     = accept && is_press && !full;
	assign pop      = accept && (req.data.op == OP_READ) && (cnt_q != '0);
	assign clear    = accept && (req.data.op == OP_CLEAR);

	sc2a_xlate u_xlate (
		.scancode (req.data.scancode[6:0]),
		.ascii    (ascii)
	);

	sc2a_char_ram #(
		.DEPTH (FIFO_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (wr_ptr_q),
		.wr_data (ascii),
		.rd_en   (pop),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	always_comb begin
		cnt_d = cnt_q;
		if (clear) begin
			cnt_d = '0;
		end else if (push) begin
			cnt_d = cnt_q + 1'b1;
		end else if (pop) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (clear) begin
				wr_ptr_q <= '0;
				rd_ptr_q <= '0;
			end else begin
				if (push) begin
					wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
				end
				if (pop) begin
					rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
				end
			end
			cnt_q <= cnt_d;
			if (accept) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_valid_s1 <= pop;
			dropped_s1    <= accept && is_press && full;
			fill_s1       <= FILL_W'(cnt_d);
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.data.char_valid = char_valid_s1;
	assign rsp.data.char_out   = char_valid_s1 ? rd_data : 8'h00;
	assign rsp.data.dropped    = dropped_s1;
	assign rsp.data.fill_level = fill_s1;

	`SC2A_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= FULL, "count above depth")
	`SC2A_ASSERT_NEXT(a_empty_read, clk, arst_n,
		accept && (req.data.op == OP_READ) && (cnt_q == '0),
		rsp.valid && !rsp.data.char_valid, "read of empty FIFO returned a character")
	`SC2A_ASSERT_NEXT(a_drop_full, clk, arst_n,
		accept && !full, !rsp.data.dropped, "drop reported while not full")
	`SC2A_ASSERT_NEXT(a_rsp_follows, clk, arst_n, accept, rsp.valid, "missing response word")

endmodule

`default_nettype wire

// ----- dv/tb_scancode_to_ascii_fifo.sv -----
// ----------------------------------------------------------------------------
// tb_scancode_to_ascii_fifo
// Drives scancode, read, clear and no-op words into the FIFO and checks each
// response word against a queue-based copy of the character FIFO.
// Directed keys first, then a fill past full with pointer wrap, a long
// receiver hold-off, and random traffic under four idling patterns.
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_fifo;

	import sc2a_pkg::*;

	localparam int FIFO_DEPTH = 1024;
	localparam logic [7:0] UNKNOWN_KEY = 8'h3F;
	localparam logic [7:0] LINE_FEED   = 8'h0A;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] ENTER_CODE = 8'h1C;
	localparam logic [7:0] SPACE_CODE = 8'h39;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n;

	sc2a_req_if req_ch ();
	sc2a_rsp_if rsp_ch ();

	scancode_to_ascii_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	string digit_row = "1234567890";
	string upper_row = "qwertyuiop";
	string home_row  = "asdfghjkl";
	string lower_row = "zxcvbnm";

	logic [7:0] held_chars[$];
	rsp_word_t  owed_rsp[$];
	rsp_word_t  exp_w;
	rsp_word_t  got_w;
	int mismatches = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int sink_hold_cycles = 0;

	always #5 clk = ~clk;

	function automatic logic [7:0] key_to_ascii(input logic [7:0] code);
		int k;
		k = int'(code[6:0]);
		if (k >= 'h02 && k <= 'h0B) return digit_row[k - 'h02];
		if (k >= 'h10 && k <= 'h19) return upper_row[k - 'h10];
		if (k >= 'h1E && k <= 'h26) return home_row[k - 'h1E];
		if (k >= 'h2C && k <= 'h32) return lower_row[k - 'h2C];
		if (k == SPACE_CODE) return SPACE_CHAR;
		if (k == ENTER_CODE) return LINE_FEED;
		return UNKNOWN_KEY;
	endfunction

	function automatic rsp_word_t apply_request(input req_word_t w);
		rsp_word_t r;
		r = '0;
		case (w.op)
			OP_SCAN: begin
				if (!w.scancode[7]) begin
					if (held_chars.size() >= FIFO_DEPTH)
						r.dropped = 1'b1;
					else
						held_chars.push_back(key_to_ascii(w.scancode));
				end
			end
			OP_READ: begin
				if (held_chars.size() != 0) begin
					r.char_valid = 1'b1;
					r.char_out = held_chars.pop_front();
				end
			end
			OP_CLEAR: held_chars.delete();
			default: ;
		endcase
		r.fill_level = FILL_W'(held_chars.size());
		return r;
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: exp v=%0d c=%h d=%0d f=%0d, got v=%0d c=%h d=%0d f=%0d",
				$realtime, what, exp_w.char_valid, exp_w.char_out, exp_w.dropped,
				exp_w.fill_level, got_w.char_valid, got_w.char_out, got_w.dropped,
				got_w.fill_level);
	endtask

	// check responses first, then predict the request taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
				got_w = rsp_ch.data;
				if (owed_rsp.size() == 0) begin
					exp_w = '0;
					note_mismatch("unexpected word");
				end else begin
					exp_w = owed_rsp.pop_front();
					if (got_w.char_valid !== exp_w.char_valid ||
					    got_w.char_out !== exp_w.char_out ||
					    got_w.dropped !== exp_w.dropped ||
					    got_w.fill_level !== exp_w.fill_level)
						note_mismatch("mismatch");
				end
			end
			if (req_ch.valid && req_ch.ready === 1'b1)
				owed_rsp.push_back(apply_request(req_ch.data));
		end
	end

	always @(negedge clk) begin
		if (sink_hold_cycles > 0) begin
			rsp_ch.ready <= 1'b0;
			sink_hold_cycles--;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [7:0] code);
		req_word_t w;
		w.op = op;
		w.scancode = code;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	task automatic wait_drain;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (owed_rsp.size() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_press;
		if ($urandom_range(1))
			return 8'($urandom_range('h39, 'h02));
		return 8'($urandom_range(127));
	endfunction

	task automatic send_random;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			send_word(OP_SCAN, rand_press());
		else if (pick < 55)
			send_word(OP_SCAN, 8'h80 | 8'($urandom_range(127)));
		else if (pick < 88)
			send_word(OP_READ, 8'($urandom_range(255)));
		else if (pick < 91)
			send_word(OP_CLEAR, 8'($urandom_range(255)));
		else
			send_word(OP_NOP, 8'($urandom_range(255)));
	endtask

	task automatic test_directed;
		send_word(OP_READ, 8'h00);
		send_word(OP_NOP, 8'hFF);
		send_word(OP_SCAN, SPACE_CODE);
		send_word(OP_SCAN, ENTER_CODE);
		send_word(OP_SCAN, 8'h00);
		send_word(OP_SCAN, 8'h7F);
		send_word(OP_SCAN, 8'h02);
		send_word(OP_SCAN, 8'h0B);
		send_word(OP_SCAN, 8'h10);
		send_word(OP_SCAN, 8'h19);
		send_word(OP_SCAN, 8'h1E);
		send_word(OP_SCAN, 8'h26);
		send_word(OP_SCAN, 8'h2C);
		send_word(OP_SCAN, 8'h32);
		send_word(OP_SCAN, 8'h80);
		send_word(OP_SCAN, 8'hFF);
		repeat (8) send_word(OP_READ, 8'hFF);
		send_word(OP_CLEAR, 8'h00);
		send_word(OP_READ, 8'h00);
		wait_drain();
	endtask

	// overfill so the write side wraps and drops, then reuse slot zero
	task automatic test_fill_and_wrap;
		send_word(OP_CLEAR, 8'h00);
		repeat (FIFO_DEPTH + 4) send_word(OP_SCAN, rand_press());
		send_word(OP_READ, 8'h00);
		send_word(OP_SCAN, rand_press());
		send_word(OP_SCAN, rand_press());
		repeat (16) send_word(OP_READ, 8'h00);
		send_word(OP_CLEAR, 8'h00);
		wait_drain();
	endtask

	task automatic test_backpressure;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		sink_hold_cycles = 300;
		repeat (40) send_random();
		wait_drain();
	endtask

	task automatic test_random_mix;
		int src_pct[4];
		int sink_pct[4];
		src_pct = '{0, 72, 0, 7};
		sink_pct = '{0, 0, 72, 7};
		for (int p = 0; p < 4; p++) begin
			src_idle_pct = src_pct[p];
			sink_stall_pct = sink_pct[p];
			repeat (195) send_random();
			wait_drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_and_wrap();
		test_backpressure();
		test_random_mix();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
